// ===== rtl/cpc_pkg.sv =====
// Shared widths, register codes and pipeline payload types for contact position correction.
package cpc_pkg;

   localparam int POS_W      = 32;
   localparam int MASS_W     = 16;
   localparam int NRM_W      = 16;
   localparam int DEPTH_W    = 31;
   localparam int SLOP_W     = 16;
   localparam int PCT_W      = 17;
   localparam int CSR_W      = 17;
   localparam int LANES      = 4;
   localparam int DEN_W      = MASS_W + 1;
   localparam int QUO_W      = 34;
   localparam int NUM_W      = 50;
   localparam int DIV_STAGES = QUO_W / 2;
   localparam int PIPE_STAGES = DIV_STAGES + 5;
   localparam int REQ_W      = 232;
   localparam int RSP_W      = 136;

   localparam logic [SLOP_W-1:0] SLOP_RESET = 16'd66;
   localparam logic [PCT_W-1:0]  PCT_RESET  = 17'd26214;
   localparam logic [POS_W-1:0]  POS_MAX    = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0]  POS_MIN    = 32'h8000_0000;

   typedef enum logic [0:0] {
      CPC_REG_SLOP    = 1'b0,
      CPC_REG_PERCENT = 1'b1
   } cpc_reg_type;

   // lanes: 0 a_x, 1 a_y, 2 b_x, 3 b_y
   typedef struct packed {
      logic [LANES-1:0][POS_W-1:0] pos;
      logic [LANES-1:0]            neg;
      logic                        mov_a;
      logic                        mov_b;
      logic [DEN_W-1:0]            den;
   } cpc_side_type;

   typedef struct packed {
      logic [LANES-1:0][DEN_W-1:0] rem;
      logic [LANES-1:0][QUO_W-1:0] dq;
   } cpc_quo_type;

endpackage

// ===== rtl/cpc_div_stage.sv =====
// One registered radix-4 restoring division stage for all four offset lanes.
module cpc_div_stage (
   input  logic                  clock,
   input  logic                  en,
   input  cpc_pkg::cpc_side_type up_side,
   input  cpc_pkg::cpc_quo_type  up_quo,
   output cpc_pkg::cpc_side_type dn_side,
   output cpc_pkg::cpc_quo_type  dn_quo
);

   cpc_pkg::cpc_side_type side_ff;
   cpc_pkg::cpc_quo_type  quo_ff;
   cpc_pkg::cpc_quo_type  quo_in;

   // Shift two dividend bits into the remainder, subtract the divisor where it fits.
   always_comb begin
      logic [cpc_pkg::DEN_W:0]   trial;
      logic [cpc_pkg::DEN_W-1:0] rem;
      logic [cpc_pkg::QUO_W-1:0] dq;
      quo_in = up_quo;
      for (int l = 0; l < cpc_pkg::LANES; l++) begin
         rem = up_quo.rem[l];
         dq  = up_quo.dq[l];
         for (int b = 0; b < 2; b++) begin
            trial = {rem, dq[cpc_pkg::QUO_W-1]};
            dq    = {dq[cpc_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, up_side.den}) begin
               trial = trial - {1'b0, up_side.den};
               dq[0] = 1'b1;
            end
            rem = trial[cpc_pkg::DEN_W-1:0];
         end
         quo_in.rem[l] = rem;
         quo_in.dq[l]  = dq;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= up_side;
         quo_ff  <= quo_in;
      end
   end

   assign dn_side = side_ff;
   assign dn_quo  = quo_ff;

endmodule

// ===== rtl/contact_position_correction_core.sv =====
// Contact position correction: pipelined linear projection of two bodies along a contact normal.
// Pipeline: four arithmetic stages, 17 divider stages, one output stage.
// Throughput: one contact per cycle while the skid register is empty; the divider retires two quotient bits per stage.
// Skid: one more contact enters after a result is refused; input then holds until it drains.
// Reset (synchronous, active high) empties the pipeline and skid and loads slop = 66,
//   percent = 26214.
module contact_position_correction_core (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata from bit 0: a_x[31:0], a_y[31:0], b_x[31:0], b_y[31:0], a_mass[15:0],
   // b_mass[15:0], a_fixed, b_fixed, normal_x[15:0], normal_y[15:0], depth[30:0], zero pad
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [cpc_pkg::REQ_W-1:0]    req_tdata,
   // rsp_tdata from bit 0: new_a_x[31:0], new_a_y[31:0], new_b_x[31:0], new_b_y[31:0],
   // moved[1:0], zero pad
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [cpc_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_we,
   input  logic [0:0]                   csr_index,
   input  logic [cpc_pkg::CSR_W-1:0]    csr_wdata
);

   // ---------------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------------
   logic [cpc_pkg::SLOP_W-1:0] slop_ff, slop_in;
   logic [cpc_pkg::PCT_W-1:0]  percent_ff, percent_in;

   always_comb begin
      slop_in    = slop_ff;
      percent_in = percent_ff;
      if (csr_we) begin
         unique case (cpc_pkg::cpc_reg_type'(csr_index))
            cpc_pkg::CPC_REG_SLOP:    slop_in    = csr_wdata[cpc_pkg::SLOP_W-1:0];
            cpc_pkg::CPC_REG_PERCENT: percent_in = csr_wdata[cpc_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff    <= cpc_pkg::SLOP_RESET;
         percent_ff <= cpc_pkg::PCT_RESET;
      end else begin
         slop_ff    <= slop_in;
         percent_ff <= percent_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Flow control: the whole pipe advances while the skid register is empty.
   // A result that is not taken drops into the skid; the pipe then holds until it drains.
   // ---------------------------------------------------------------------------------------
   logic                              en;
   logic [cpc_pkg::PIPE_STAGES-1:0]   v_ff, v_in;
   logic                              skid_v_ff, skid_v_in;
   logic [cpc_pkg::RSP_W-1:0]         skid_data_ff;
   logic [cpc_pkg::RSP_W-1:0]         out_data_ff, out_data_in;

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign rsp_tvalid = skid_v_ff || v_ff[cpc_pkg::PIPE_STAGES-1];
   assign rsp_tdata  = skid_v_ff ? skid_data_ff : out_data_ff;

   always_comb begin
      v_in = v_ff;
      if (en) begin
         v_in = {v_ff[cpc_pkg::PIPE_STAGES-2:0], req_tvalid};
      end
      if (skid_v_ff) begin
         skid_v_in = !rsp_tready;
      end else begin
         skid_v_in = v_ff[cpc_pkg::PIPE_STAGES-1] && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         skid_v_ff <= 1'b0;
      end else begin
         v_ff      <= v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Field unpack
   // ---------------------------------------------------------------------------------------
   logic [cpc_pkg::POS_W-1:0]   f_a_x, f_a_y, f_b_x, f_b_y;
   logic [cpc_pkg::MASS_W-1:0]  f_a_mass, f_b_mass;
   logic                        f_a_fixed, f_b_fixed;
   logic [cpc_pkg::NRM_W-1:0]   f_normal_x, f_normal_y;
   logic [cpc_pkg::DEPTH_W-1:0] f_depth;

   assign f_a_x      = req_tdata[31:0];
   assign f_a_y      = req_tdata[63:32];
   assign f_b_x      = req_tdata[95:64];
   assign f_b_y      = req_tdata[127:96];
   assign f_a_mass   = req_tdata[143:128];
   assign f_b_mass   = req_tdata[159:144];
   assign f_a_fixed  = req_tdata[160];
   assign f_b_fixed  = req_tdata[161];
   assign f_normal_x = req_tdata[177:162];
   assign f_normal_y = req_tdata[193:178];
   assign f_depth    = req_tdata[224:194];

   // ---------------------------------------------------------------------------------------
   // Stage 1: excess depth, gate, mass weights, normal magnitudes, depth times percent.
   // ---------------------------------------------------------------------------------------
   logic [cpc_pkg::POS_W-1:0]   d_net;
   logic                        go_net;
   logic [cpc_pkg::DEN_W-1:0]   mass_sum_net;
   logic [cpc_pkg::DEN_W-1:0]   den_net;
   logic [cpc_pkg::MASS_W-1:0]  wa_net, wb_net;
   logic [cpc_pkg::NRM_W-1:0]   mag_x_net, mag_y_net;
   logic [47:0]                 dp_net;
   cpc_pkg::cpc_side_type       side1_net;

   // Signed excess over slop; zero or negative means no correction.
   assign d_net        = {1'b0, f_depth} - {16'b0, slop_ff};
   assign go_net       = !(f_a_fixed && f_b_fixed) && !d_net[cpc_pkg::POS_W-1]
                         && (d_net != '0);
   assign mass_sum_net = {1'b0, f_a_mass} + {1'b0, f_b_mass};
   assign mag_x_net    = f_normal_x[cpc_pkg::NRM_W-1] ? (~f_normal_x + 16'd1) : f_normal_x;
   assign mag_y_net    = f_normal_y[cpc_pkg::NRM_W-1] ? (~f_normal_y + 16'd1) : f_normal_y;
   assign dp_net       = d_net[cpc_pkg::POS_W-2:0] * percent_ff;

   // One free body takes all of it (w = den = 1). Both free: split by the other body's mass,
   // or in half when neither has mass.
   always_comb begin
      den_net = 17'd1;
      wa_net  = 16'd1;
      wb_net  = 16'd1;
      if (!f_a_fixed && !f_b_fixed) begin
         if (mass_sum_net == '0) begin
            den_net = 17'd2;
         end else begin
            den_net = mass_sum_net;
            wa_net  = f_b_mass;
            wb_net  = f_a_mass;
         end
      end
   end

   always_comb begin
      side1_net.pos   = {f_b_y, f_b_x, f_a_y, f_a_x};
      side1_net.neg   = {f_normal_y[cpc_pkg::NRM_W-1], f_normal_x[cpc_pkg::NRM_W-1],
                         f_normal_y[cpc_pkg::NRM_W-1], f_normal_x[cpc_pkg::NRM_W-1]};
      side1_net.mov_a = go_net && !f_a_fixed;
      side1_net.mov_b = go_net && !f_b_fixed;
      side1_net.den   = den_net;
   end

   cpc_pkg::cpc_side_type        s1_side_ff;
   logic [47:0]                  s1_dp_ff;
   logic [cpc_pkg::NRM_W-1:0]    s1_mag_x_ff, s1_mag_y_ff;
   logic [cpc_pkg::MASS_W-1:0]   s1_wa_ff, s1_wb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff  <= side1_net;
         s1_dp_ff    <= dp_net;
         s1_mag_x_ff <= mag_x_net;
         s1_mag_y_ff <= mag_y_net;
         s1_wa_ff    <= wa_net;
         s1_wb_ff    <= wb_net;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2: round the correction length to Q16.16, weight the normal magnitudes.
   // ---------------------------------------------------------------------------------------
   logic [47:0]                                 round_net;
   logic [cpc_pkg::POS_W-1:0]                   s_net;
   logic [cpc_pkg::LANES-1:0][31:0]             wm_net;

   assign round_net = s1_dp_ff + 48'd32768;
   assign s_net     = round_net[47:16];

   always_comb begin
      wm_net[0] = s1_wa_ff * s1_mag_x_ff;
      wm_net[1] = s1_wa_ff * s1_mag_y_ff;
      wm_net[2] = s1_wb_ff * s1_mag_x_ff;
      wm_net[3] = s1_wb_ff * s1_mag_y_ff;
   end

   cpc_pkg::cpc_side_type               s2_side_ff;
   logic [cpc_pkg::POS_W-1:0]           s2_s_ff;
   logic [cpc_pkg::LANES-1:0][31:0]     s2_wm_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_side_ff <= s1_side_ff;
         s2_s_ff    <= s_net;
         s2_wm_ff   <= wm_net;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 3: full product |n| * s * w per lane (32 x 32).
   // ---------------------------------------------------------------------------------------
   logic [cpc_pkg::LANES-1:0][63:0] prod_net;

   always_comb begin
      for (int l = 0; l < cpc_pkg::LANES; l++) begin
         prod_net[l] = s2_wm_ff[l] * s2_s_ff;
      end
   end

   cpc_pkg::cpc_side_type           s3_side_ff;
   logic [cpc_pkg::LANES-1:0][63:0] s3_prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_side_ff <= s2_side_ff;
         s3_prod_ff <= prod_net;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 4: add half the divisor, drop the 2^14 scale, load the divider.
   // floor((p + den*2^13) / (den*2^14)) = floor(floor((p + den*2^13) / 2^14) / den).
   // The quotient stays below 2^34, so the top 16 dividend bits start as the remainder.
   // ---------------------------------------------------------------------------------------
   logic [cpc_pkg::LANES-1:0][63:0] biased_net;
   cpc_pkg::cpc_quo_type            quo4_net;

   always_comb begin
      for (int l = 0; l < cpc_pkg::LANES; l++) begin
         biased_net[l]   = s3_prod_ff[l] + {34'b0, s3_side_ff.den, 13'b0};
         quo4_net.rem[l] = {1'b0, biased_net[l][63:48]};
         quo4_net.dq[l]  = biased_net[l][47:14];
      end
   end

   cpc_pkg::cpc_side_type s4_side_ff;
   cpc_pkg::cpc_quo_type  s4_quo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff <= s3_side_ff;
         s4_quo_ff  <= quo4_net;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Divider: 17 stages of two quotient bits each, shared divisor for all four lanes.
   // ---------------------------------------------------------------------------------------
   cpc_pkg::cpc_side_type div_side [cpc_pkg::DIV_STAGES+1];
   cpc_pkg::cpc_quo_type  div_quo  [cpc_pkg::DIV_STAGES+1];

   assign div_side[0] = s4_side_ff;
   assign div_quo[0]  = s4_quo_ff;

   for (genvar g = 0; g < cpc_pkg::DIV_STAGES; g++) begin : g_div
      cpc_div_stage u_stage (
         .clock   (clock),
         .en      (en),
         .up_side (div_side[g]),
         .up_quo  (div_quo[g]),
         .dn_side (div_side[g+1]),
         .dn_quo  (div_quo[g+1])
      );
   end

   // ---------------------------------------------------------------------------------------
   // Output stage: sign the offsets, push A against the normal and B along it, saturate.
   // A body that does not move passes its position through untouched.
   // ---------------------------------------------------------------------------------------
   cpc_pkg::cpc_side_type side_o;
   cpc_pkg::cpc_quo_type  quo_o;

   assign side_o = div_side[cpc_pkg::DIV_STAGES];
   assign quo_o  = div_quo[cpc_pkg::DIV_STAGES];

   always_comb begin
      logic [cpc_pkg::QUO_W:0]                      off;
      logic [cpc_pkg::POS_W+3:0]                    base;
      logic [cpc_pkg::POS_W+3:0]                    offx;
      logic [cpc_pkg::POS_W+3:0]                    sum;
      logic                                         mov;
      logic [cpc_pkg::LANES-1:0][cpc_pkg::POS_W-1:0] res;
      for (int l = 0; l < cpc_pkg::LANES; l++) begin
         off  = side_o.neg[l] ? (~{1'b0, quo_o.dq[l]} + 35'd1) : {1'b0, quo_o.dq[l]};
         base = {{4{side_o.pos[l][cpc_pkg::POS_W-1]}}, side_o.pos[l]};
         offx = {off[cpc_pkg::QUO_W], off};
         if (l < 2) begin
            sum = base - offx;
            mov = side_o.mov_a;
         end else begin
            sum = base + offx;
            mov = side_o.mov_b;
         end
         if (!mov) begin
            res[l] = side_o.pos[l];
         end else if ((sum[35:31] == 5'b00000) || (sum[35:31] == 5'b11111)) begin
            res[l] = sum[cpc_pkg::POS_W-1:0];
         end else if (sum[35]) begin
            res[l] = cpc_pkg::POS_MIN;
         end else begin
            res[l] = cpc_pkg::POS_MAX;
         end
      end
      out_data_in = {6'b0, side_o.mov_b, side_o.mov_a, res[3], res[2], res[1], res[0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff  <= out_data_in;
         skid_data_ff <= out_data_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   // The divisor is never zero, including the both-free, zero-mass case.
   assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> (s1_side_ff.den != '0))
      else $error("zero divisor entered the pipeline");

   // Every lane leaves the divider with a remainder below its divisor.
   assert property (@(posedge clock) disable iff (reset)
      v_ff[cpc_pkg::DIV_STAGES+3] |->
         (quo_o.rem[0] < side_o.den) && (quo_o.rem[1] < side_o.den) &&
         (quo_o.rem[2] < side_o.den) && (quo_o.rem[3] < side_o.den))
      else $error("divider remainder out of range");

   // Reset empties the pipeline and the skid register.
   assert property (@(posedge clock)
      reset |=> ((v_ff == '0) && !skid_v_ff))
      else $error("pipeline not empty after reset");

endmodule

// ===== tb/contact_position_correction_checker.sv =====
// Checker for contact_position_correction_core: predicts each corrected contact and compares it.
`timescale 1ns / 100ps

module contact_position_correction_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [cpc_pkg::REQ_W-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [cpc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [cpc_pkg::CSR_W-1:0] csr_wdata,
   output int                        open_count,
   output int                        error_count,
   output int                        checked_count
);

   // contact layout, highest field first
   typedef struct packed {
      logic [6:0]                  pad;
      logic [cpc_pkg::DEPTH_W-1:0] depth;
      logic signed [15:0]          normal_y;
      logic signed [15:0]          normal_x;
      logic                        b_fixed;
      logic                        a_fixed;
      logic [cpc_pkg::MASS_W-1:0]  b_mass;
      logic [cpc_pkg::MASS_W-1:0]  a_mass;
      logic signed [31:0]          b_y;
      logic signed [31:0]          b_x;
      logic signed [31:0]          a_y;
      logic signed [31:0]          a_x;
   } contact_type;

   typedef struct packed {
      logic [5:0]                pad;
      logic [1:0]                moved;
      logic [cpc_pkg::POS_W-1:0] b_y;
      logic [cpc_pkg::POS_W-1:0] b_x;
      logic [cpc_pkg::POS_W-1:0] a_y;
      logic [cpc_pkg::POS_W-1:0] a_x;
   } placement_type;

   logic [cpc_pkg::SLOP_W-1:0] slop_q;
   logic [cpc_pkg::PCT_W-1:0]  percent_q;
   placement_type              placement_q[$];
   placement_type              want;
   placement_type              got;

   initial begin
      error_count   = 0;
      checked_count = 0;
      open_count    = 0;
   end

   // Signed push along one axis: |n| * len * w / (den * 2^14), halves away from zero.
   function automatic longint axis_push(logic signed [15:0] n, logic [63:0] len,
                                        logic [63:0] w, logic [63:0] den);
      longint      n_wide;
      logic [63:0] mag;
      logic [63:0] div;
      logic [63:0] q;
      n_wide = n;
      mag    = (n_wide < 0) ? -n_wide : n_wide;
      div    = den << 14;
      q      = (mag * len * w + div / 2) / div;
      return (n_wide < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [cpc_pkg::POS_W-1:0] clamp_pos(longint v);
      if (v > 64'sh0000_0000_7FFF_FFFF) return cpc_pkg::POS_MAX;
      if (v < 64'shFFFF_FFFF_8000_0000) return cpc_pkg::POS_MIN;
      return v[cpc_pkg::POS_W-1:0];
   endfunction

   function automatic placement_type predict_placement(contact_type c,
                                                       logic [cpc_pkg::SLOP_W-1:0] slop,
                                                       logic [cpc_pkg::PCT_W-1:0] pct);
      placement_type r;
      longint        ax;
      longint        ay;
      longint        bx;
      longint        by;
      longint        excess;
      logic [63:0]   excess_u;
      logic [63:0]   len;
      logic [63:0]   wa;
      logic [63:0]   wb;
      logic [63:0]   den;
      logic [1:0]    moved;
      ax     = c.a_x;
      ay     = c.a_y;
      bx     = c.b_x;
      by     = c.b_y;
      excess = longint'({33'b0, c.depth}) - longint'({48'b0, slop});
      moved  = 2'b00;
      if (!(c.a_fixed && c.b_fixed) && excess > 0) begin
         excess_u = excess;
         len      = (excess_u * {47'b0, pct} + 64'h8000) >> 16;
         wa       = 1;
         wb       = 1;
         den      = 1;
         if (!c.a_fixed && !c.b_fixed) begin
            den = {48'b0, c.a_mass} + {48'b0, c.b_mass};
            // massless pair: split evenly
            if (den == 0) begin
               den = 2;
            end else begin
               wa = {48'b0, c.b_mass};
               wb = {48'b0, c.a_mass};
            end
         end
         if (!c.a_fixed) begin
            ax       = ax - axis_push(c.normal_x, len, wa, den);
            ay       = ay - axis_push(c.normal_y, len, wa, den);
            moved[0] = 1'b1;
         end
         if (!c.b_fixed) begin
            bx       = bx + axis_push(c.normal_x, len, wb, den);
            by       = by + axis_push(c.normal_y, len, wb, den);
            moved[1] = 1'b1;
         end
      end
      r       = '0;
      r.a_x   = clamp_pos(ax);
      r.a_y   = clamp_pos(ay);
      r.b_x   = clamp_pos(bx);
      r.b_y   = clamp_pos(by);
      r.moved = moved;
      return r;
   endfunction

   task automatic check_field(string what, logic [cpc_pkg::POS_W-1:0] want_v,
                              logic [cpc_pkg::POS_W-1:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         $display("%0t: result %0d %s expected %h, actual %h",
                  $time, checked_count, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         placement_q.delete();
         slop_q     <= cpc_pkg::SLOP_RESET;
         percent_q  <= cpc_pkg::PCT_RESET;
         open_count <= 0;
      end else begin
         if (csr_we) begin
            case (cpc_pkg::cpc_reg_type'(csr_index))
               cpc_pkg::CPC_REG_SLOP:    slop_q    <= csr_wdata[cpc_pkg::SLOP_W-1:0];
               cpc_pkg::CPC_REG_PERCENT: percent_q <= csr_wdata[cpc_pkg::PCT_W-1:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (placement_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = placement_q.pop_front();
               check_field("new_a_x", want.a_x, got.a_x);
               check_field("new_a_y", want.a_y, got.a_y);
               check_field("new_b_x", want.b_x, got.b_x);
               check_field("new_b_y", want.b_y, got.b_y);
               check_field("moved", {30'b0, want.moved}, {30'b0, got.moved});
            end
            checked_count++;
         end
         if (req_tvalid && req_tready)
            placement_q.push_back(predict_placement(req_tdata, slop_q, percent_q));
         open_count <= placement_q.size();
      end
   end

endmodule

// ===== tb/contact_position_correction_core_test.sv =====
// Top of the contact position correction testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module contact_position_correction_core_test;

   localparam int MAX_GAP    = 12;
   localparam int HOLD_SPAN  = 300;  // long output hold-off, well past pipeline + skid depth
   localparam int TAIL_WAIT  = 30;   // longer than the pipeline latency

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [cpc_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [cpc_pkg::RSP_W-1:0] rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [0:0]                csr_index  = cpc_pkg::CPC_REG_SLOP;
   logic [cpc_pkg::CSR_W-1:0] csr_wdata  = '0;

   int open_count;
   int error_count;
   int checked_count;

   int                         sent_count     = 0;
   int                         settings_count = 0;
   int                         holds_done     = 0;
   bit                         hold_request   = 1'b0;
   bit                         send_calm      = 1'b0;
   bit                         rsp_calm       = 1'b0;
   logic [cpc_pkg::SLOP_W-1:0] slop_now       = cpc_pkg::SLOP_RESET;

   contact_position_correction_core i_dut (.*);

   contact_position_correction_checker i_checker (.*);

   // 10 ns clock, low half first
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs; far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: draw a stall per transfer, with calm stretches and one long hold-off
   // on request so the pipeline and skid fill up and back-pressure the input.
   initial begin : rsp_side
      int stall;
      forever begin
         if (hold_request) begin
            stall        = HOLD_SPAN;
            hold_request = 1'b0;
            holds_done++;
         end else begin
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            stall = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Idle for the given gap, then offer one contact and hold it until the transfer.
   task automatic send_contact(int gap, logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                               logic [31:0] by, logic [15:0] ma, logic [15:0] mb,
                               logic afix, logic bfix, logic [15:0] nx, logic [15:0] ny,
                               logic [cpc_pkg::DEPTH_W-1:0] dep);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {7'b0, dep, ny, nx, bfix, afix, mb, ma, by, bx, ay, ax};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   function automatic logic [31:0] pick_position();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return cpc_pkg::POS_MAX - $urandom_range(0, 32'h000F_FFFF);
         2:       return cpc_pkg::POS_MIN + $urandom_range(0, 32'h000F_FFFF);
         default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      endcase
   endfunction

   function automatic logic [15:0] pick_mass();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 20));
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly in-range normals; sometimes zero, unit axes or any 16-bit pattern.
   function automatic logic [15:0] pick_normal();
      case ($urandom_range(0, 7))
         0:       return 16'($urandom);
         1:       return 16'd0;
         2:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   // Depth clustered around the current slop, spread wide, or anywhere in range.
   function automatic logic [cpc_pkg::DEPTH_W-1:0] pick_depth();
      int near;
      case ($urandom_range(0, 3))
         0: return (cpc_pkg::DEPTH_W)'($urandom);
         1: begin
            near = int'(slop_now) + int'($urandom_range(0, 64)) - 32;
            return (near < 0) ? '0 : (cpc_pkg::DEPTH_W)'(near);
         end
         default: return (cpc_pkg::DEPTH_W)'($urandom_range(0, 32'h003F_FFFF));
      endcase
   endfunction

   task automatic send_random_contact(bit burst);
      int         gap;
      logic [1:0] fixed;
      if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      gap   = (burst || send_calm) ? 0 : $urandom_range(0, MAX_GAP);
      fixed = 2'($urandom);
      send_contact(gap, pick_position(), pick_position(), pick_position(), pick_position(),
                   pick_mass(), pick_mass(), fixed[0], fixed[1], pick_normal(),
                   pick_normal(), pick_depth());
   endtask

   // Drop valid and wait until every predicted result has transferred out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   task automatic write_reg(cpc_pkg::cpc_reg_type idx, logic [cpc_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == cpc_pkg::CPC_REG_SLOP) slop_now = value[cpc_pkg::SLOP_W-1:0];
   endtask

   // Registers change only with the pipeline empty.
   task automatic set_config(logic [cpc_pkg::CSR_W-1:0] slop_v,
                             logic [cpc_pkg::CSR_W-1:0] percent_v);
      drain_results();
      write_reg(cpc_pkg::CPC_REG_SLOP, slop_v);
      write_reg(cpc_pkg::CPC_REG_PERCENT, percent_v);
      settings_count++;
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      settings_count = 1;

      // Directed contacts under the reset settings.
      // both bodies fixed: pass through
      send_contact($urandom_range(0, MAX_GAP), 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                   32'h0003_0000, 16'd10, 16'd20, 1'b1, 1'b1, 16'sd16384, 16'sd0,
                   31'd1000000);
      // depth equal to slop, zero depth, then just below slop: nothing moves
      send_contact($urandom_range(0, MAX_GAP), 32'h0001_0000, 32'h0, 32'h0, 32'h0,
                   16'd1, 16'd1, 1'b0, 1'b0, 16'sd16384, 16'sd0, 31'd66);
      send_contact($urandom_range(0, MAX_GAP), 32'h0001_0000, 32'h0, 32'h0, 32'h0,
                   16'd1, 16'd1, 1'b0, 1'b0, 16'sd16384, 16'sd0, 31'd0);
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0, 32'h0,
                   16'd2, 16'd9, 1'b0, 1'b1, 16'sd16384, 16'sd0, 31'd65);
      // just above slop: offset rounds to zero, both still flagged as moved
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0, 32'h0,
                   16'd1, 16'd1, 1'b0, 1'b0, 16'sd16384, 16'sd0, 31'd67);
      // one body free takes the whole push
      send_contact($urandom_range(0, MAX_GAP), 32'h0005_0000, 32'hFFFB_0000, 32'h0, 32'h0,
                   16'd3, 16'd4, 1'b0, 1'b1, 16'sd0, -16'sd16384, 31'h0010_0000);
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0007_0000, 32'h0007_0000,
                   16'd3, 16'd4, 1'b1, 1'b0, 16'sd11585, 16'sd11585, 31'h0010_0000);
      // both free: equal masses, massless pair, one massless side
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0, 32'h0,
                   16'd5, 16'd5, 1'b0, 1'b0, 16'sd16384, 16'sd1000, 31'h0020_0000);
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0, 32'h0,
                   16'd0, 16'd0, 1'b0, 1'b0, -16'sd9000, 16'sd13000, 31'h0020_0000);
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0, 32'h0,
                   16'd0, 16'd100, 1'b0, 1'b0, 16'sd16384, -16'sd16384, 31'h0020_0000);
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0, 32'h0,
                   16'd100, 16'd0, 1'b0, 1'b0, 16'sd16384, -16'sd16384, 31'h0020_0000);
      // heaviest masses with deepest penetration
      send_contact($urandom_range(0, MAX_GAP), 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0,
                   16'hFFFF, 16'hFFFF, 1'b0, 1'b0, -16'sd16384, 16'sd16384, 31'h7FFF_FFFF);
      // normal outside its nominal range is used as given
      send_contact($urandom_range(0, MAX_GAP), 32'h0, 32'h0, 32'h0, 32'h0,
                   16'd1, 16'hFFFF, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 31'h0400_0000);
      // every coordinate driven into saturation, both normal signs
      send_contact($urandom_range(0, MAX_GAP), cpc_pkg::POS_MIN, cpc_pkg::POS_MAX,
                   cpc_pkg::POS_MAX, cpc_pkg::POS_MIN, 16'd3, 16'd7, 1'b0, 1'b0,
                   16'sd16384, -16'sd16384, 31'h7FFF_FFFF);
      send_contact($urandom_range(0, MAX_GAP), cpc_pkg::POS_MAX, cpc_pkg::POS_MIN,
                   cpc_pkg::POS_MIN, cpc_pkg::POS_MAX, 16'd3, 16'd7, 1'b0, 1'b0,
                   -16'sd16384, 16'sd16384, 31'h7FFF_FFFF);
      // zero normal: moved but no offset
      send_contact($urandom_range(0, MAX_GAP), 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0,
                   16'd8, 16'd8, 1'b0, 1'b0, 16'sd0, 16'sd0, 31'h4000_0000);
      // smallest nonzero normal components
      send_contact($urandom_range(0, MAX_GAP), 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                   32'h0, 16'hFFFF, 16'd1, 1'b0, 1'b0, -16'sd1, 16'sd1, 31'h5555_5555);

      // Extreme settings: no slop, full percent.
      set_config('0, 17'd65536);
      repeat (100) send_random_contact(1'b0);

      // Largest slop, zero percent: offsets vanish but bodies still count as moved.
      set_config(17'h0FFFF, '0);
      repeat (60) send_random_contact(1'b0);

      // Percent beyond one, applied unclamped; slop write carries a stray high bit.
      set_config(17'h10000 | 17'($urandom_range(0, 65535)), 17'h1FFFF);
      repeat (60) send_random_contact(1'b0);

      // Back to reset values; hold results off while contacts keep streaming in.
      set_config(17'(cpc_pkg::SLOP_RESET), 17'(cpc_pkg::PCT_RESET));
      hold_request = 1'b1;
      repeat (60) send_random_contact(1'b1);
      repeat (90) send_random_contact(1'b0);

      // A few random settings.
      repeat (4) begin
         set_config(17'($urandom), 17'($urandom));
         repeat (40) send_random_contact(1'b0);
      end

      // Wait for the last results, then a latency's worth more for strays.
      drain_results();
      repeat (TAIL_WAIT) @(posedge clock);

      $display("summary: %0d contacts under %0d register settings, %0d results checked",
               sent_count, settings_count, checked_count);
      $display("summary: %0d long output hold-off(s), %0d mismatch(es), %0d left open",
               holds_done, error_count, open_count);
      if (error_count == 0 && open_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
